// ===== rtl/xs128_pkg.sv =====
// Shared types and constants for the xorshift128 bounded random block.
package xs128_pkg;

    typedef logic [31:0] t_word;

    localparam t_word START_X     = 32'd123456789;
    localparam t_word START_Y     = 32'd362436069;
    localparam t_word START_Z     = 32'd521288629;
    localparam t_word ZERO_SEED_W = 32'd88675123;
    localparam t_word RESET_SEED  = 32'hFFFF_FFFF;
    localparam t_word WORD_MAX    = 32'hFFFF_FFFF;

    localparam int SHIFT_A = 11;
    localparam int SHIFT_B = 19;
    localparam int SHIFT_C = 8;

    localparam logic OP_RAW     = 1'b0;
    localparam logic OP_BOUNDED = 1'b1;

    typedef enum logic [2:0] {
        ST_WARM,
        ST_IDLE,
        ST_SETUP,
        ST_LIMIT,
        ST_DRAW,
        ST_MOD,
        ST_FINISH,
        ST_DONE
    } t_state;

    // One xorshift128 step: returns the new fourth word.
    function automatic t_word xs_next(input t_word x, input t_word w);
        t_word t;
        t = x ^ (x << SHIFT_A);
        return (w ^ (w >> SHIFT_B)) ^ (t ^ (t >> SHIFT_C));
    endfunction

endpackage

// ===== rtl/xs128_req_if.sv =====
// Request channel: valid/ready handshake with the draw request fields.
interface xs128_req_if;
    import xs128_pkg::*;

    logic         valid;
    logic         ready;
    logic         operation;
    logic signed [31:0] range_lower;
    logic signed [31:0] range_upper;
    logic         upper_inclusive;

    modport source (
        output valid, operation, range_lower, range_upper, upper_inclusive,
        input  ready
    );
    modport sink (
        input  valid, operation, range_lower, range_upper, upper_inclusive,
        output ready
    );
endinterface

// ===== rtl/xs128_rsp_if.sv =====
// Response channel: valid/ready handshake with the draw result fields.
interface xs128_rsp_if;
    import xs128_pkg::*;

    logic         valid;
    logic         ready;
    t_word        raw_word;
    logic signed [31:0] bounded_value;

    modport source (
        output valid, raw_word, bounded_value,
        input  ready
    );
    modport sink (
        input  valid, raw_word, bounded_value,
        output ready
    );
endinterface

// ===== rtl/xorshift128_bounded_random.sv =====
// Xorshift128 generator with raw and bounded (rejection sampled) integer draws.
// After reset or a seed write the block runs WARMUP_STEPS generator steps, one per cycle,
// and does not take requests meanwhile. A raw request goes through setup and one generator
// step to done, and waits there until the output register is free to take its result. A
// bounded request takes one pass of the shared bit-serial remainder unit for the rejection
// limit and one more for the draw modulo span, plus a redraw per rejected draw. An empty
// or wrapped range goes from setup straight to done; the next request is taken in idle.
// One request is in flight at a time; the next one is accepted while a result waits in
// the output register.
module xorshift128_bounded_random #(
    parameter int WARMUP_STEPS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_seed_we,
    input  xs128_pkg::t_word i_seed_wdata,
    xs128_req_if.sink        i_req,
    xs128_rsp_if.source      o_rsp
);
    import xs128_pkg::*;

    localparam int CntW = (WARMUP_STEPS > 0) ? $clog2(WARMUP_STEPS + 1) : 1;

    t_state n_state, r_state;

    t_word r_x, r_y, r_z, r_w;
    logic [CntW-1:0] r_warm_cnt;

    // latched request
    logic  r_op;
    t_word r_lo, r_hi;
    logic  r_incl;

    t_word r_span, r_lim;

    // shared remainder unit
    t_word      r_rem, r_dvd;
    logic [4:0] r_div_cnt;

    t_word r_res_raw, r_res_val;

    logic  r_out_valid;
    t_word r_out_raw, r_out_val;

    // control strobes
    logic s_ready, s_step, s_div_step, s_out_load;

    t_word       w_new;
    t_word       span;
    logic        empty;
    logic        span_bad;
    logic [32:0] rem_sh, rem_diff;
    t_word       rem_n;
    logic        draw_ok;
    logic        out_free;

    assign w_new    = xs_next(r_x, r_w);
    assign span     = r_hi - r_lo + {31'd0, r_incl};
    assign empty    = $signed(r_lo) >= $signed(r_hi);
    assign span_bad = empty || (span == '0) || span[31];

    assign rem_sh   = {r_rem, r_dvd[31]};
    assign rem_diff = rem_sh - {1'b0, r_span};
    assign rem_n    = rem_diff[32] ? rem_sh[31:0] : rem_diff[31:0];

    assign draw_ok  = (r_op == OP_RAW) || (w_new < r_lim);
    assign out_free = !r_out_valid || o_rsp.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_WARM:   if (r_warm_cnt == '0) n_state = ST_IDLE;
            ST_IDLE:   if (i_req.valid) n_state = ST_SETUP;
            ST_SETUP: begin
                if (r_op == OP_RAW) begin
                    n_state = ST_DRAW;
                end else if (span_bad) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_LIMIT;
                end
            end
            ST_LIMIT:  if (r_div_cnt == '0) n_state = ST_DRAW;
            ST_DRAW: begin
                if (draw_ok) n_state = (r_op == OP_RAW) ? ST_DONE : ST_MOD;
            end
            ST_MOD:    if (r_div_cnt == '0) n_state = ST_FINISH;
            ST_FINISH: n_state = ST_DONE;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready    = 1'b0;
        s_step     = 1'b0;
        s_div_step = 1'b0;
        s_out_load = 1'b0;
        unique case (r_state)
            ST_WARM:   s_step = (r_warm_cnt != '0);
            ST_IDLE:   s_ready = 1'b1;
            ST_LIMIT:  s_div_step = 1'b1;
            ST_DRAW:   s_step = 1'b1;
            ST_MOD:    s_div_step = 1'b1;
            ST_DONE:   s_out_load = out_free;
            default:   s_ready = 1'b0;
        endcase
    end

    assign i_req.ready = s_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_WARM;
            r_x        <= START_X;
            r_y        <= START_Y;
            r_z        <= START_Z;
            r_w        <= RESET_SEED;
            r_warm_cnt <= CntW'(WARMUP_STEPS);
        end else if (i_seed_we) begin
            r_state    <= ST_WARM;
            r_x        <= START_X;
            r_y        <= START_Y;
            r_z        <= START_Z;
            r_w        <= (i_seed_wdata != '0) ? i_seed_wdata : ZERO_SEED_W;
            r_warm_cnt <= CntW'(WARMUP_STEPS);
        end else begin
            r_state <= n_state;
            if (s_step) begin
                r_x <= r_y;
                r_y <= r_z;
                r_z <= r_w;
                r_w <= w_new;
            end
            if (r_state == ST_WARM && r_warm_cnt != '0) begin
                r_warm_cnt <= r_warm_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // datapath (no reset needed)
    always_ff @(posedge i_clk) begin
        if (s_ready && i_req.valid) begin
            r_op   <= i_req.operation;
            r_lo   <= t_word'(i_req.range_lower);
            r_hi   <= t_word'(i_req.range_upper);
            r_incl <= i_req.upper_inclusive;
        end

        if (r_state == ST_SETUP) begin
            r_span    <= span;
            r_res_raw <= '0;
            r_res_val <= (r_op == OP_RAW) ? '0 : r_lo;
            // remainder unit computes WORD_MAX mod span
            r_rem     <= '0;
            r_dvd     <= WORD_MAX;
            r_div_cnt <= 5'd31;
        end

        if (s_div_step) begin
            r_rem     <= rem_n;
            r_dvd     <= {r_dvd[30:0], 1'b0};
            r_div_cnt <= r_div_cnt - 1'b1;
            if (r_state == ST_LIMIT && r_div_cnt == '0) begin
                r_lim <= ~rem_n;    // WORD_MAX - rem
            end
        end

        if (r_state == ST_DRAW && draw_ok) begin
            r_res_raw <= w_new;
            r_rem     <= '0;
            r_dvd     <= w_new;
            r_div_cnt <= 5'd31;
        end

        if (r_state == ST_FINISH) begin
            r_res_val <= r_lo + r_rem;
        end

        if (s_out_load) begin
            r_out_raw <= r_res_raw;
            r_out_val <= r_res_val;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.raw_word      = r_out_raw;
    assign o_rsp.bounded_value = $signed(r_out_val);

`ifndef SYNTHESIS
    a_seed_restarts_warmup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_seed_we |=> (r_state == ST_WARM))
        else $error("seed write did not restart warm-up");

    a_span_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIMIT || r_state == ST_MOD) |-> (r_span != '0 && !r_span[31]))
        else $error("remainder unit running with an unusable span");

    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> (r_rem < r_span))
        else $error("remainder not below span");

    a_state_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_x | r_y | r_z | r_w) != '0)
        else $error("generator state collapsed to zero");
`endif

endmodule
